>>> rtl/efd_pkg.sv
// ----------------------------------------------------------------------------
// efd_pkg
// Shared types and constants for the EEG frame deframer: controller states,
// configuration register indexes, reset values and the command and status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package efd_pkg;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_START  = 2'd0,
    CFG_END    = 2'd1,
    CFG_LENGTH = 2'd2,
    CFG_SCALE  = 2'd3
  } cfg_reg_t;

  localparam int CFG_DATA_W = 24;

  // Register reset values
  localparam logic [7:0]  START_RESET  = 8'd160;
  localparam logic [7:0]  END_RESET    = 8'd192;
  localparam logic [6:0]  LENGTH_RESET = 7'd21;
  localparam logic [23:0] SCALE_RESET  = 24'd8000000;

  // Shortest frame accepted as a length setting
  localparam logic [6:0] MIN_FRAME = 7'd18;

  // Controller states
  typedef enum logic [2:0] {
    ST_RECV,
    ST_READ_HI,
    ST_READ_LO,
    ST_RAW,
    ST_PROD,
    ST_SEND
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic take;       // byte transaction accepted this cycle
    logic rd_lo;      // read low sample byte, latch high byte
    logic load_raw;   // assemble the 16-bit sample
    logic load_prod;  // register the scaled product
    logic send_done;  // result transaction accepted this cycle
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic frame_good; // current byte closes a good, in-sequence frame
    logic last_chan;  // channel counter sits on the final channel
  } status_t;

endpackage

>>> rtl/efd_ctrl.sv
// ----------------------------------------------------------------------------
// efd_ctrl
// Controller for the EEG frame deframer. Takes bytes while receiving, and
// on a good frame walks every channel through read, assemble, scale, send.
// ----------------------------------------------------------------------------
module efd_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             rx_valid,
  input  logic             res_stall,
  input  efd_pkg::status_t status,
  output efd_pkg::cmd_t    cmd,
  output logic             rx_stall,
  output logic             res_valid
);

  efd_pkg::state_t state;
  efd_pkg::state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= efd_pkg::ST_RECV;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next    = state;
    cmd           = '0;
    rx_stall      = 1'b1;
    res_valid     = 1'b0;
    case (state)
      efd_pkg::ST_RECV: begin
        rx_stall = 1'b0;
        cmd.take = rx_valid;
        if (rx_valid && status.frame_good) begin
          state_next = efd_pkg::ST_READ_HI;
        end
      end
      efd_pkg::ST_READ_HI: begin
        state_next = efd_pkg::ST_READ_LO;
      end
      efd_pkg::ST_READ_LO: begin
        cmd.rd_lo  = 1'b1;
        state_next = efd_pkg::ST_RAW;
      end
      efd_pkg::ST_RAW: begin
        cmd.load_raw = 1'b1;
        state_next   = efd_pkg::ST_PROD;
      end
      efd_pkg::ST_PROD: begin
        cmd.load_prod = 1'b1;
        state_next    = efd_pkg::ST_SEND;
      end
      efd_pkg::ST_SEND: begin
        res_valid = 1'b1;
        if (!res_stall) begin
          cmd.send_done = 1'b1;
          state_next    = status.last_chan ? efd_pkg::ST_RECV : efd_pkg::ST_READ_HI;
        end
      end
      default: begin
        state_next = efd_pkg::ST_RECV;
      end
    endcase
  end

endmodule

>>> rtl/efd_datapath.sv
// ----------------------------------------------------------------------------
// efd_datapath
// Datapath for the EEG frame deframer: configuration registers, framing and
// sequence tracking, the frame byte store, sample assembly and scaling.
// ----------------------------------------------------------------------------
module efd_datapath #(
  parameter int CHANNELS  = 8,
  parameter int MAX_FRAME = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  input  efd_pkg::cmd_t                      cmd,
  input  logic                               cfg_write,
  input  logic [1:0]                         cfg_index,
  input  logic [efd_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [7:0]                         rx_byte,
  output efd_pkg::status_t                   status,
  output logic [2:0]                         channel,
  output logic signed [15:0]                 raw_sample,
  output logic signed [39:0]                 scaled_value,
  output logic [31:0]                        frame_number,
  output logic                               last_channel
);

  localparam int AW = $clog2(MAX_FRAME);
  localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [6:0]    MaxLen   = 7'(MAX_FRAME);
  localparam logic [CW-1:0] LastChan = CW'(CHANNELS - 1);

  // Configuration
  logic [7:0]  start_marker;
  logic [7:0]  end_marker;
  logic [6:0]  frame_length;
  logic [23:0] scale_q16;

  // Framing state
  logic [6:0]  byte_position;
  logic [7:0]  expected_index;
  logic        index_known;
  logic        discard_next;
  logic [7:0]  index_byte;
  logic [31:0] good_frame_count;
  logic [CW-1:0] chan;

  // Store and sample path
  logic [7:0]  frame_store [MAX_FRAME];
  logic [7:0]  rd_data;
  logic [7:0]  hi_byte;
  logic signed [15:0] raw;
  logic signed [39:0] product;

  logic [6:0]    active_len;
  logic [6:0]    pos_inc;
  logic          frame_end;
  logic          end_ok;
  logic          seq_ok;
  logic          store_en;
  logic [6:0]    chan_ext;
  logic [6:0]    hi_addr;
  logic [6:0]    lo_addr;
  logic [AW-1:0] rd_addr;
  logic signed [40:0] prod_full;

  // Saturate the frame length to the supported range
  always_comb begin
    if (frame_length < efd_pkg::MIN_FRAME) begin
      active_len = efd_pkg::MIN_FRAME;
    end else if (frame_length > MaxLen) begin
      active_len = MaxLen;
    end else begin
      active_len = frame_length;
    end
  end

  // Frame completion and acceptance checks on the incoming byte
  assign pos_inc   = byte_position + 7'd1;
  assign frame_end = (byte_position != 7'd0) && ((pos_inc == 7'd0) || (pos_inc >= active_len));
  assign end_ok    = (rx_byte == end_marker);
  assign seq_ok    = !index_known || (index_byte == expected_index);
  assign store_en  = cmd.take && !discard_next && (byte_position != 7'd0) &&
                     (byte_position < MaxLen);

  assign status.frame_good = !discard_next && frame_end && end_ok && seq_ok;
  assign status.last_chan  = (chan == LastChan);

  // Control state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      start_marker     <= efd_pkg::START_RESET;
      end_marker       <= efd_pkg::END_RESET;
      frame_length     <= efd_pkg::LENGTH_RESET;
      scale_q16        <= efd_pkg::SCALE_RESET;
      byte_position    <= 7'd0;
      expected_index   <= 8'd0;
      index_known      <= 1'b0;
      discard_next     <= 1'b0;
      good_frame_count <= 32'd0;
      chan             <= '0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          efd_pkg::CFG_START:  start_marker <= cfg_data[7:0];
          efd_pkg::CFG_END:    end_marker   <= cfg_data[7:0];
          efd_pkg::CFG_LENGTH: frame_length <= cfg_data[6:0];
          efd_pkg::CFG_SCALE:  scale_q16    <= cfg_data[23:0];
          default: ;
        endcase
      end
      // Advance the framing state on each accepted byte
      if (cmd.take) begin
        if (discard_next) begin
          discard_next <= 1'b0;
        end else if (byte_position == 7'd0) begin
          if (rx_byte == start_marker) begin
            byte_position <= 7'd1;
          end
        end else if (frame_end) begin
          byte_position <= 7'd0;
          if (!end_ok) begin
            discard_next <= 1'b1;
          end else begin
            expected_index <= index_byte + 8'd1;
            index_known    <= 1'b1;
          end
        end else begin
          byte_position <= pos_inc;
        end
      end
      // Step the channel counter, count the frame after its final channel
      if (cmd.send_done) begin
        if (status.last_chan) begin
          chan             <= '0;
          good_frame_count <= good_frame_count + 32'd1;
        end else begin
          chan <= chan + CW'(1);
        end
      end
    end
  end

  // Hold the sequence index byte of the frame in progress
  always_ff @(posedge clk) begin
    if (cmd.take && !discard_next && (byte_position == 7'd1)) begin
      index_byte <= rx_byte;
    end
  end

  // Sample byte addresses for the current channel
  assign chan_ext = 7'(chan);
  assign hi_addr  = {chan_ext[5:0], 1'b0} + 7'd1;
  assign lo_addr  = {chan_ext[5:0], 1'b0} + 7'd2;
  assign rd_addr  = cmd.rd_lo ? lo_addr[AW-1:0] : hi_addr[AW-1:0];

  // Frame byte store, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (store_en) begin
      frame_store[byte_position[AW-1:0]] <= rx_byte;
    end
    rd_data <= frame_store[rd_addr];
  end

  // Assemble the sample and scale it
  assign prod_full = raw * $signed({1'b0, scale_q16});

  always_ff @(posedge clk) begin
    if (cmd.rd_lo) begin
      hi_byte <= rd_data;
    end
    if (cmd.load_raw) begin
      raw <= $signed({hi_byte, rd_data});
    end
    if (cmd.load_prod) begin
      product <= prod_full[39:0];
    end
  end

  assign channel      = 3'(chan);
  assign raw_sample   = raw;
  assign scaled_value = product;
  assign frame_number = good_frame_count;
  assign last_channel = status.last_chan;

endmodule

>>> rtl/eeg_frame_deframer_unit.sv
// ----------------------------------------------------------------------------
// eeg_frame_deframer_unit
// Parses start/end byte framed EEG packets and emits one scaled sample per
// channel for each good, in-sequence frame.
// ----------------------------------------------------------------------------
// Usage:
//   Received bytes enter on rx_valid/rx_stall/rx_byte, one per transaction.
//   Results leave on res_valid/res_stall with channel, raw_sample,
//   scaled_value, frame_number and last_channel; a good frame gives
//   CHANNELS result transactions, channel 0 first, last_channel on the final.
//   Configuration writes use cfg_write/cfg_index/cfg_data, no wait states.
// Timing:
//   Bytes are taken while receiving. The byte that closes a good frame starts
//   emission: each channel goes through two reads through the one read
//   port of the frame store, sample assembly, one registered multiply and
//   send, and result stalls lengthen it; no byte is taken before the final
//   channel is sent. rx_stall stays high for the whole emission.
// Reset:
//   rst is synchronous; it clears framing state, the good frame count and
//   the sequence tracking, and loads the register defaults.
//   While res_stall is high on a result, that result holds and nothing advances.
// ----------------------------------------------------------------------------
module eeg_frame_deframer_unit #(
  parameter int CHANNELS  = 8,
  parameter int MAX_FRAME = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [1:0]                     cfg_index,
  input  logic [efd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           rx_valid,
  output logic                           rx_stall,
  input  logic [7:0]                     rx_byte,
  output logic                           res_valid,
  input  logic                           res_stall,
  output logic [2:0]                     channel,
  output logic signed [15:0]             raw_sample,
  output logic signed [39:0]             scaled_value,
  output logic [31:0]                    frame_number,
  output logic                           last_channel
);

  efd_pkg::cmd_t    cmd;
  efd_pkg::status_t status;

  efd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .rx_valid  (rx_valid),
    .res_stall (res_stall),
    .status    (status),
    .cmd       (cmd),
    .rx_stall  (rx_stall),
    .res_valid (res_valid)
  );

  efd_datapath #(
    .CHANNELS  (CHANNELS),
    .MAX_FRAME (MAX_FRAME)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .rx_byte      (rx_byte),
    .status       (status),
    .channel      (channel),
    .raw_sample   (raw_sample),
    .scaled_value (scaled_value),
    .frame_number (frame_number),
    .last_channel (last_channel)
  );

  // No byte is taken while a result is on offer
  assert property (@(posedge clk) disable iff (rst) res_valid |-> rx_stall)
    else $error("byte accepted during result emission");

  // After the final channel, return to receiving
  assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_stall && last_channel) |=> (!res_valid && !rx_stall))
    else $error("emission did not end after final channel");

  // The good frame count steps once per emitted frame
  assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_stall && last_channel) |=> (frame_number == $past(frame_number) + 32'd1))
    else $error("frame count did not advance");

  // Next channel of the same frame follows after the read and scale steps
  assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_stall && !last_channel) |=> ##4
      (res_valid && channel == $past(channel, 5) + 3'd1 &&
       frame_number == $past(frame_number, 5)))
    else $error("channel sequence broken");

endmodule

>>> dv/eeg_frame_deframer_unit_test.sv
// ----------------------------------------------------------------------------
// eeg_frame_deframer_unit_test
// Self-checking bench for the EEG frame deframer. A queue-fed driver sends
// received bytes with random gaps, and the result side stalls at random. A
// monitor runs a cycle-free deframer on every accepted byte and checks each
// result transaction, field by field, against the oldest predicted sample.
// Register settings change between phases, only once the block is idle.
// ----------------------------------------------------------------------------
module eeg_frame_deframer_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CHANNELS  = 8;
  localparam int MAX_FRAME = 64;
  localparam int IDLE_WAIT = 5 * CHANNELS + 10;
  localparam int PHASES    = 7;

  typedef struct {
    logic [2:0]         channel;
    logic signed [15:0] raw;
    logic signed [39:0] scaled;
    logic [31:0]        frame_no;
    logic               last;
  } sample_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           cfg_write = 1'b0;
  logic [1:0]                     cfg_index = efd_pkg::CFG_START;
  logic [efd_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic                           rx_valid = 1'b0;
  logic                           rx_stall;
  logic [7:0]                     rx_byte = 8'd0;
  logic                           res_valid;
  logic                           res_stall = 1'b0;
  logic [2:0]                     channel;
  logic signed [15:0]             raw_sample;
  logic signed [39:0]             scaled_value;
  logic [31:0]                    frame_number;
  logic                           last_channel;

  // Register shadows
  logic [7:0]  reg_start = efd_pkg::START_RESET;
  logic [7:0]  reg_end   = efd_pkg::END_RESET;
  logic [6:0]  reg_len   = efd_pkg::LENGTH_RESET;
  logic [23:0] reg_scale = efd_pkg::SCALE_RESET;

  // Deframer state
  logic [7:0]  frm_store [MAX_FRAME] = '{default: 8'd0};
  logic [6:0]  frm_pos     = 7'd0;
  logic [7:0]  next_index  = 8'd0;
  logic        index_seen  = 1'b0;
  logic        skip_byte   = 1'b0;
  logic [31:0] good_frames = 32'd0;

  logic [7:0] rx_pending [$];
  sample_t    due_samples [$];
  int         mismatches = 0;
  int         fed_bytes  = 0;
  int         tx_gap     = 0;
  int         stall_left = 0;
  bit         steady     = 1'b0;
  logic [7:0] seq_idx;

  eeg_frame_deframer_unit #(
    .CHANNELS  (CHANNELS),
    .MAX_FRAME (MAX_FRAME)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .rx_valid     (rx_valid),
    .rx_stall     (rx_stall),
    .rx_byte      (rx_byte),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .channel      (channel),
    .raw_sample   (raw_sample),
    .scaled_value (scaled_value),
    .frame_number (frame_number),
    .last_channel (last_channel)
  );

  always #5 clk = ~clk;

  // Frame length in use: the register saturated to the legal range
  function automatic int unsigned frame_span();
    if (reg_len < efd_pkg::MIN_FRAME) return 32'(efd_pkg::MIN_FRAME);
    if (reg_len > MAX_FRAME) return MAX_FRAME;
    return 32'(reg_len);
  endfunction

  // Mostly short gaps, a few long ones, none in steady phases
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Advance the deframer by one accepted byte, queue any samples it yields
  task automatic deframe_byte(input logic [7:0] b);
    sample_t            s;
    logic [15:0]        word;
    logic signed [39:0] raw_ext;
    logic signed [39:0] scl_ext;
    if (skip_byte) begin
      skip_byte = 1'b0;
      return;
    end
    if (frm_pos == 7'd0) begin
      if (b == reg_start) begin
        frm_store[0] = b;
        frm_pos = 7'd1;
      end
      return;
    end
    if (frm_pos < MAX_FRAME) frm_store[frm_pos] = b;
    frm_pos = frm_pos + 7'd1;
    if (frm_pos != 7'd0 && frm_pos < frame_span()) return;
    frm_pos = 7'd0;
    // misaligned frame: drop it and the byte after
    if (b != reg_end) begin
      skip_byte = 1'b1;
      return;
    end
    // out of sequence: drop and resync on this index
    if (index_seen && frm_store[1] != next_index) begin
      next_index = frm_store[1] + 8'd1;
      return;
    end
    next_index = frm_store[1] + 8'd1;
    index_seen = 1'b1;
    scl_ext = {16'd0, reg_scale};
    for (int c = 0; c < CHANNELS; c++) begin
      word       = {frm_store[1 + 2 * c], frm_store[2 + 2 * c]};
      raw_ext    = $signed(word);
      s.channel  = c[2:0];
      s.raw      = word;
      s.scaled   = raw_ext * scl_ext;
      s.frame_no = good_frames;
      s.last     = (c == CHANNELS - 1);
      due_samples.push_back(s);
    end
    good_frames = good_frames + 32'd1;
  endtask

  task automatic write_reg(input efd_pkg::cfg_reg_t idx,
                           input logic [efd_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      efd_pkg::CFG_START:  reg_start = val[7:0];
      efd_pkg::CFG_END:    reg_end   = val[7:0];
      efd_pkg::CFG_LENGTH: reg_len   = val[6:0];
      efd_pkg::CFG_SCALE:  reg_scale = val[23:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic feed(input logic [7:0] b);
    rx_pending.push_back(b);
    fed_bytes++;
  endtask

  // Queue one frame at the current length; a bad end is followed by a byte
  // that the block must throw away, often the start marker itself
  task automatic queue_frame(input logic [7:0] idx, input bit bad_end);
    int unsigned n;
    n = frame_span();
    feed(reg_start);
    feed(idx);
    for (int k = 2; k < n - 1; k++) feed(8'($urandom_range(0, 255)));
    if (bad_end) begin
      feed(reg_end ^ 8'($urandom_range(1, 255)));
      feed($urandom_range(0, 1) ? reg_start : 8'($urandom_range(0, 255)));
    end else begin
      feed(reg_end);
    end
  endtask

  // Hold until the block is idle: all bytes taken, all samples back;
  // sample away from the rising edge so driver and monitor updates are seen
  task automatic settle();
    do @(negedge clk);
    while (rx_pending.size() != 0 || rx_valid || due_samples.size() != 0);
    repeat (IDLE_WAIT) @(posedge clk);
  endtask

  // Byte driver
  always @(posedge clk) begin
    if (rst) begin
      rx_valid <= 1'b0;
    end else if (!rx_valid || !rx_stall) begin
      if (tx_gap > 0) begin
        tx_gap--;
        rx_valid <= 1'b0;
      end else if (rx_pending.size() > 0) begin
        rx_byte  <= rx_pending.pop_front();
        rx_valid <= 1'b1;
        tx_gap   = pick_gap();
      end else begin
        rx_valid <= 1'b0;
      end
    end
  end

  // Result-side stall
  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      res_stall <= 1'b1;
    end else begin
      stall_left = pick_gap();
      res_stall <= (stall_left > 0);
      if (stall_left > 0) stall_left--;
    end
  end

  // Monitor: predict on byte transactions, check result transactions
  always @(posedge clk) begin : monitor
    sample_t want;
    if (!rst) begin
      if (rx_valid && !rx_stall) deframe_byte(rx_byte);
      if (res_valid && !res_stall) begin
        if (due_samples.size() == 0) begin
          $error("unexpected result: channel %0d raw_sample %0d", channel, raw_sample);
          mismatches++;
        end else begin
          want = due_samples.pop_front();
          if (channel !== want.channel) begin
            $error("channel: expected %0d, got %0d", want.channel, channel);
            mismatches++;
          end
          if (raw_sample !== want.raw) begin
            $error("raw_sample: expected %0d, got %0d", want.raw, raw_sample);
            mismatches++;
          end
          if (scaled_value !== want.scaled) begin
            $error("scaled_value: expected %0d, got %0d", want.scaled, scaled_value);
            mismatches++;
          end
          if (frame_number !== want.frame_no) begin
            $error("frame_number: expected %0d, got %0d", want.frame_no, frame_number);
            mismatches++;
          end
          if (last_channel !== want.last) begin
            $error("last_channel: expected %0b, got %0b", want.last, last_channel);
            mismatches++;
          end
        end
      end
    end
  end

  // Stimulus
  initial begin : stimulus
    logic [7:0] intro [23];
    logic [7:0] idx;
    logic [7:0] b;
    int         target;
    int         r;
    int         part;
    intro = '{8'h00, 8'hFF,
              8'hA0, 8'hFF, 8'h00, 8'h7F, 8'hFF, 8'h80, 8'h00, 8'h00, 8'h00,
              8'hFF, 8'hFF, 8'h00, 8'h01, 8'h55, 8'hAA, 8'h12, 8'h34,
              8'hDE, 8'hAD, 8'hA0, 8'hC0};
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: noise while hunting, then a frame of extreme samples at the
    // reset settings, index 0xFF so that the random part wraps the sequence
    foreach (intro[i]) feed(intro[i]);
    seq_idx = 8'h00;

    for (int p = 0; p < PHASES; p++) begin
      // Registers change only once the block has gone idle
      settle();
      case (p)
        1: begin
          write_reg(efd_pkg::CFG_START, 24'h00);
          write_reg(efd_pkg::CFG_END, 24'hFF);
          write_reg(efd_pkg::CFG_LENGTH, 24'd0);
          write_reg(efd_pkg::CFG_SCALE, 24'hFFFFFF);
        end
        2: begin
          write_reg(efd_pkg::CFG_START, 24'hFF);
          write_reg(efd_pkg::CFG_END, 24'h00);
          write_reg(efd_pkg::CFG_LENGTH, 24'd18);
          write_reg(efd_pkg::CFG_SCALE, 24'd0);
        end
        3: begin
          write_reg(efd_pkg::CFG_START, 24'($urandom_range(0, 255)));
          write_reg(efd_pkg::CFG_END, 24'($urandom_range(0, 255)));
          write_reg(efd_pkg::CFG_LENGTH, 24'd127);
          write_reg(efd_pkg::CFG_SCALE, 24'($urandom_range(0, 24'hFFFFFF)));
        end
        4: begin
          write_reg(efd_pkg::CFG_LENGTH, 24'd64);
          write_reg(efd_pkg::CFG_SCALE, 24'($urandom_range(0, 24'hFFFFFF)));
        end
        5: begin
          write_reg(efd_pkg::CFG_START, 24'($urandom_range(0, 255)));
          write_reg(efd_pkg::CFG_LENGTH, 24'($urandom_range(19, 30)));
          write_reg(efd_pkg::CFG_SCALE, 24'($urandom_range(0, 24'hFFFFFF)));
        end
        6: begin
          write_reg(efd_pkg::CFG_START, 24'(efd_pkg::START_RESET));
          write_reg(efd_pkg::CFG_END, 24'(efd_pkg::END_RESET));
          write_reg(efd_pkg::CFG_LENGTH, 24'($urandom_range(18, 24)));
          write_reg(efd_pkg::CFG_SCALE, 24'd1);
        end
        default: ;
      endcase
      steady = (p % 3 == 2);

      // Mostly in-sequence frames, some broken ones and hunting noise
      target = fed_bytes + 18;
      while (fed_bytes < target) begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          queue_frame(seq_idx, 1'b0);
          seq_idx = seq_idx + 8'd1;
        end else if (r < 75) begin
          queue_frame(seq_idx, 1'b1);
        end else if (r < 87) begin
          idx = seq_idx + 8'($urandom_range(1, 255));
          queue_frame(idx, 1'b0);
          seq_idx = idx + 8'd1;
        end else begin
          repeat ($urandom_range(1, 4)) begin
            do b = 8'($urandom_range(0, 255));
            while (b == reg_start);
            rx_pending.push_back(b);
          end
        end
      end

      // Leave a frame half collected so the next length applies mid-frame
      if ($urandom_range(0, 1)) begin
        part = $urandom_range(1, (frame_span() - 2 < 30) ? frame_span() - 2 : 30);
        feed(reg_start);
        repeat (part) feed(8'($urandom_range(0, 255)));
      end
    end

    settle();
    if (mismatches == 0 && due_samples.size() == 0) begin
      $display("eeg_frame_deframer_unit_test: PASS");
    end else begin
      $display("eeg_frame_deframer_unit_test: FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("eeg_frame_deframer_unit_test: FAIL");
    $finish;
  end

endmodule

>>> files.f
rtl/efd_pkg.sv
rtl/efd_ctrl.sv
rtl/efd_datapath.sv
rtl/eeg_frame_deframer_unit.sv
dv/eeg_frame_deframer_unit_test.sv
